// File: rtl/utf8_stream_decoder_unit_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a condition on every clock edge outside reset.
`define U8D_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Check that a condition implies another one in the same cycle.
`define U8D_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define U8D_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define U8D_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned StW   = 2;
  localparam int unsigned LineW = 32;

  // Result queue geometry
  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  // Status codes
  localparam logic [StW-1:0] ST_CHAR    = 2'd0;
  localparam logic [StW-1:0] ST_INVALID = 2'd1;
  localparam logic [StW-1:0] ST_END     = 2'd2;

  // Value limits
  localparam logic [CpW-1:0] MIN_2B   = 21'h000080;
  localparam logic [CpW-1:0] MIN_3B   = 21'h000800;
  localparam logic [CpW-1:0] MIN_4B   = 21'h010000;
  localparam logic [CpW-1:0] MAX_CP   = 21'h10FFFF;
  localparam logic [9:0]     SURR_HI  = 10'h01B;  // bits 20:11 of 0xD800..0xDFFF
  localparam logic [7:0]     NEWLINE  = 8'h0A;
  localparam logic [LineW-1:0] LINE_MAX = '1;

  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic [LenW-1:0]  seq_length;
    logic [StW-1:0]   status;
    logic [LineW-1:0] line_number;
    logic             last_of_run;
  } res_t;

  // Results of one decoded item, handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// File: rtl/u8d_decode.sv
`include "utf8_stream_decoder_unit_defines.svh"

module u8d_decode (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld,
  input  logic [7:0]              byte_in,
  output u8d_pkg::push_t          push
);

  logic [1:0]                     pend_r, pend_nxt;
  logic [u8d_pkg::CpW-1:0]        pv_r, pv_nxt;
  logic [u8d_pkg::LenW-1:0]       slen_r, slen_nxt;
  logic [u8d_pkg::LineW-1:0]      line_r, line_nxt;

  logic                           lead_emit;
  u8d_pkg::res_t                  lead_res;
  logic [1:0]                     lead_pend;
  logic [u8d_pkg::CpW-1:0]        lead_pv;
  logic [u8d_pkg::LenW-1:0]       lead_len;

  logic [u8d_pkg::CpW-1:0]        pv_cat;
  logic                           val_ok;
  logic                           is_trail;

  // Count newlines, saturating at the top
  always_comb begin
    line_nxt = line_r;
    if (vld && byte_in == u8d_pkg::NEWLINE && line_r != u8d_pkg::LINE_MAX) begin
      line_nxt = line_r + 32'd1;
    end
  end

  // Decode the byte as a sequence lead
  always_comb begin
    lead_emit = 1'b1;
    lead_res  = '0;
    lead_pend = 2'd0;
    lead_pv   = '0;
    lead_len  = '0;
    lead_res.line_number = line_nxt;
    lead_res.last_of_run = 1'b1;
    if (byte_in == 8'h00) begin
      lead_res.status = u8d_pkg::ST_END;
    end else if (byte_in[7] == 1'b0) begin
      lead_res.code_point = {13'd0, byte_in};
      lead_res.seq_length = 3'd1;
      lead_res.status     = u8d_pkg::ST_CHAR;
    end else if (byte_in[7:5] == 3'b110) begin
      lead_emit = 1'b0;
      lead_pend = 2'd1;
      lead_pv   = {16'd0, byte_in[4:0]};
      lead_len  = 3'd2;
    end else if (byte_in[7:4] == 4'b1110) begin
      lead_emit = 1'b0;
      lead_pend = 2'd2;
      lead_pv   = {17'd0, byte_in[3:0]};
      lead_len  = 3'd3;
    end else if (byte_in[7:3] == 5'b11110) begin
      lead_emit = 1'b0;
      lead_pend = 2'd3;
      lead_pv   = {18'd0, byte_in[2:0]};
      lead_len  = 3'd4;
    end else begin
      lead_res.seq_length = 3'd1;
      lead_res.status     = u8d_pkg::ST_INVALID;
    end
  end

  // Append a trail byte and range-check the completed value
  assign is_trail = (byte_in[7:6] == 2'b10);
  assign pv_cat   = {pv_r[14:0], byte_in[5:0]};

  always_comb begin
    case (slen_r)
      3'd2:    val_ok = (pv_cat >= u8d_pkg::MIN_2B);
      3'd3:    val_ok = (pv_cat >= u8d_pkg::MIN_3B) && (pv_cat[20:11] != u8d_pkg::SURR_HI);
      3'd4:    val_ok = (pv_cat >= u8d_pkg::MIN_4B) && (pv_cat <= u8d_pkg::MAX_CP);
      default: val_ok = 1'b0;
    endcase
  end

  // Form results and next sequence state
  always_comb begin
    push     = '0;
    pend_nxt = pend_r;
    pv_nxt   = pv_r;
    slen_nxt = slen_r;
    if (vld) begin
      if (pend_r != 2'd0 && is_trail) begin
        if (pend_r == 2'd1) begin
          push.cnt            = 2'd1;
          push.r0.code_point  = val_ok ? pv_cat : '0;
          push.r0.seq_length  = slen_r;
          push.r0.status      = val_ok ? u8d_pkg::ST_CHAR : u8d_pkg::ST_INVALID;
          push.r0.line_number = line_nxt;
          push.r0.last_of_run = 1'b1;
          pend_nxt = 2'd0;
          pv_nxt   = '0;
          slen_nxt = '0;
        end else begin
          pend_nxt = pend_r - 2'd1;
          pv_nxt   = pv_cat;
        end
      end else if (pend_r != 2'd0) begin
        // Interrupted sequence: flag it, then restart on this byte
        push.r0.seq_length  = slen_r - {1'b0, pend_r};
        push.r0.status      = u8d_pkg::ST_INVALID;
        push.r0.line_number = line_nxt;
        push.r0.last_of_run = 1'b0;
        push.r1  = lead_res;
        push.cnt = lead_emit ? 2'd2 : 2'd1;
        pend_nxt = lead_pend;
        pv_nxt   = lead_pv;
        slen_nxt = lead_len;
      end else begin
        push.r0  = lead_res;
        push.cnt = lead_emit ? 2'd1 : 2'd0;
        pend_nxt = lead_pend;
        pv_nxt   = lead_pv;
        slen_nxt = lead_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      pv_r   <= '0;
      slen_r <= '0;
      line_r <= 32'd1;
    end else begin
      pend_r <= pend_nxt;
      pv_r   <= pv_nxt;
      slen_r <= slen_nxt;
      line_r <= line_nxt;
    end
  end

  `U8D_ASSERT_IMPLIES(a_open_len, clk, rst_n, pend_r != 2'd0, slen_r > {1'b0, pend_r})
  `U8D_ASSERT_ALWAYS(a_line_nonzero, clk, rst_n, line_r != '0)

endmodule

// File: rtl/u8d_queue.sv
`include "utf8_stream_decoder_unit_defines.svh"

module u8d_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  u8d_pkg::push_t            push,
  input  logic                      pop_ready,
  output logic                      pop_valid,
  output u8d_pkg::res_t             pop_data,
  output logic [u8d_pkg::QCntW-1:0] count
);

  u8d_pkg::res_t                    mem_r [u8d_pkg::QDepth];
  logic [u8d_pkg::QPtrW-1:0]        wp_r, wp_nxt;
  logic [u8d_pkg::QPtrW-1:0]        rp_r, rp_nxt;
  logic [u8d_pkg::QCntW-1:0]        cnt_r, cnt_nxt;
  logic [u8d_pkg::QPtrW-1:0]        wp_inc;
  logic                             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rp_r];
  assign count     = cnt_r;
  assign wp_inc    = wp_r + 1'b1;

  // Advance pointers by the number of items pushed and popped
  always_comb begin
    wp_nxt  = wp_r + u8d_pkg::QPtrW'(push.cnt);
    rp_nxt  = rp_r + u8d_pkg::QPtrW'(pop);
    cnt_nxt = cnt_r + u8d_pkg::QCntW'(push.cnt) - u8d_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store up to two results per cycle
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_inc] <= push.r1;
    end
  end

  `U8D_ASSERT_ALWAYS(a_no_overflow, clk, rst_n,
    ({1'b0, cnt_r} + {2'b00, push.cnt}) <= u8d_pkg::QDepth)
  `U8D_ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= u8d_pkg::QDepth)

endmodule

// File: rtl/utf8_stream_decoder_unit.sv
// Channel   Ports                                          Handshake
// input     in_byte                                        in_valid / in_ready
// result    out_code_point, out_seq_length, out_status,    out_valid / out_ready
//           out_line_number, out_last_of_run
//
// One byte is taken per cycle if in_ready is high; it is registered, decoded and queued.
// A byte gives zero, one or two results; the result port moves one item per cycle
// while out_ready is high, so the two results of one byte leave one after the other.
// An eight-entry result queue decouples the sides; in_ready drops when it cannot
// take two more results for the byte in the input register and the one arriving.
// rst_n is synchronous, active low; it clears the sequence state and sets the line to 1.
module utf8_stream_decoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [u8d_pkg::CpW-1:0]      out_code_point,
  output logic [u8d_pkg::LenW-1:0]     out_seq_length,
  output logic [u8d_pkg::StW-1:0]      out_status,
  output logic [u8d_pkg::LineW-1:0]    out_line_number,
  output logic                         out_last_of_run
);

  logic [7:0]                    byte_r;
  logic                          vld_r;
  u8d_pkg::push_t                push;
  u8d_pkg::res_t                 head;
  logic [u8d_pkg::QCntW-1:0]     qcnt;
  logic [u8d_pkg::QCntW:0]       need;

  // Reserve room for the byte in flight and the one being taken
  assign need     = {1'b0, qcnt} + (vld_r ? (u8d_pkg::QCntW+1)'(2) : '0);
  assign in_ready = (need <= (u8d_pkg::QCntW+1)'(u8d_pkg::QDepth - 2));

  // Hold the accepted byte for decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  u8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld     (vld_r),
    .byte_in (byte_r),
    .push    (push)
  );

  u8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_data  (head),
    .count     (qcnt)
  );

  assign out_code_point  = head.code_point;
  assign out_seq_length  = head.seq_length;
  assign out_status      = head.status;
  assign out_line_number = head.line_number;
  assign out_last_of_run = head.last_of_run;

endmodule
